### rtl/htw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel package
// Shared codes, constants and interface structs of the timing wheel blocks.
// ----------------------------------------------------------------------------
package htw_pkg;

  // Divider geometry: numerator, divisor and iteration counter widths.
  localparam int unsigned DIV_NW = 33;
  localparam int unsigned DIV_DW = 16;
  localparam int unsigned DIV_CW = 6;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_DW = 16;
  localparam int unsigned CFG_IW = 1;
  localparam logic [CFG_IW-1:0] CFG_TICK_PERIOD  = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_SLOTS_IN_USE = 1'd1;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_EXPIRE = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADIV1,
    ST_ADIV2,
    ST_ADIV3,
    ST_ARES,
    ST_TDIV,
    ST_RD,
    ST_EV,
    ST_FIN
  } st_e;

  typedef struct packed {
    logic              start;
    logic              short_len;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [DIV_DW-1:0] period;
    logic [DIV_DW-1:0] slots;
  } cfg_t;

  typedef struct packed {
    op_e         opcode;
    logic [3:0]  timer_number;
    logic [31:0] time_span;
  } item_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [3:0] expired_timer;
    logic       last;
    logic [4:0] active_count;
  } res_t;

endpackage

### rtl/htw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timing wheel divider
// Restoring radix-2 divider, one quotient bit per cycle, with a short mode
// for small numerators.
// ----------------------------------------------------------------------------
module htw_div #(
  parameter int unsigned SHORT_ITERS = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  htw_pkg::div_req_t req_i,
  output htw_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NW = htw_pkg::DIV_NW;
  localparam int unsigned DW = htw_pkg::DIV_DW;
  localparam int unsigned CW = htw_pkg::DIV_CW;

  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [NW-1:0] acc_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, acc_q[NW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (req_i.start) begin
        cnt_q <= req_i.short_len ? CW'(SHORT_ITERS) : CW'(NW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.short_len ? (req_i.num << (NW - SHORT_ITERS)) : req_i.num;
      rem_q <= '0;
      dvs_q <= req_i.dvs;
    end else if (cnt_q != '0) begin
      acc_q <= {acc_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;
  assign rsp_o.rem  = rem_q;

endmodule

### rtl/htw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timing wheel engine
// Sequencer over the timer table memory: arms timers and scans the table on
// each tick, with per-timer armed flags and an active counter.
// ----------------------------------------------------------------------------
module htw_core #(
  parameter int unsigned NUM_TIMERS  = 16,
  parameter int unsigned WHEEL_SLOTS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  htw_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  htw_pkg::item_t    in_item_i,
  output htw_pkg::res_t     res_o,
  input  logic              res_ready_i,
  output htw_pkg::div_req_t div_req_o,
  input  htw_pkg::div_rsp_t div_rsp_i
);

  localparam int unsigned TW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned SW   = $clog2(WHEEL_SLOTS);
  localparam int unsigned CNTW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned EW   = SW + 32;
  localparam int unsigned NW   = htw_pkg::DIV_NW;

  htw_pkg::st_e          st_q, st_d;
  logic [SW-1:0]         cur_q, cur_d;
  logic [TW-1:0]         idx_q, idx_d;
  logic                  hold_v_q, hold_v_d;
  logic [TW-1:0]         hold_idx_q, hold_idx_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;
  logic [NUM_TIMERS-1:0] armed_q, armed_d;
  logic [31:0]           rounds_q, rounds_d;
  logic [3:0]            timer_q, timer_d;

  logic [EW-1:0] mem [NUM_TIMERS];
  logic [EW-1:0] rd_q;
  logic          rd_en;
  logic          wr_en;
  logic [TW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [31:0]   ticks;
  logic [SW-1:0] ent_slot;
  logic [31:0]   ent_rounds;
  logic          hit;
  logic          expire;
  logic          idx_last;
  logic [TW-1:0] tsel;
  logic [CNTW-1:0] cnt_dec;

  assign ticks      = (div_rsp_i.quot[31:0] == 32'd0) ? 32'd1 : div_rsp_i.quot[31:0];
  assign ent_slot   = rd_q[EW-1:32];
  assign ent_rounds = rd_q[31:0];
  assign hit        = (ent_slot == cur_q);
  assign expire     = hit && (ent_rounds <= 32'd1);
  assign idx_last   = (idx_q == TW'(NUM_TIMERS - 1));
  assign tsel       = TW'(timer_q);
  assign cnt_dec    = cnt_q - CNTW'(1);
  assign in_ready_o = (st_q == htw_pkg::ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= htw_pkg::ST_IDLE;
      cur_q    <= '0;
      idx_q    <= '0;
      hold_v_q <= 1'b0;
      cnt_q    <= '0;
      armed_q  <= '0;
    end else begin
      st_q     <= st_d;
      cur_q    <= cur_d;
      idx_q    <= idx_d;
      hold_v_q <= hold_v_d;
      cnt_q    <= cnt_d;
      armed_q  <= armed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_idx_q <= hold_idx_d;
    rounds_q   <= rounds_d;
    timer_q    <= timer_d;
  end

  always_comb begin
    st_d       = st_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    hold_v_d   = hold_v_q;
    hold_idx_d = hold_idx_q;
    cnt_d      = cnt_q;
    armed_d    = armed_q;
    rounds_d   = rounds_q;
    timer_d    = timer_q;
    div_req_o  = '0;
    res_o      = '0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_data    = rd_q;

    case (st_q)
      htw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          timer_d = in_item_i.timer_number;
          if (in_item_i.opcode == htw_pkg::OP_ADD) begin
            if (32'(in_item_i.timer_number) < NUM_TIMERS) begin
              div_req_o.start = 1'b1;
              div_req_o.num   = {1'b0, in_item_i.time_span} + NW'(cfg_i.period) - NW'(1);
              div_req_o.dvs   = cfg_i.period;
              st_d            = htw_pkg::ST_ADIV1;
            end else begin
              st_d = htw_pkg::ST_ARES;
            end
          end else begin
            div_req_o.start     = 1'b1;
            div_req_o.short_len = 1'b1;
            div_req_o.num       = NW'(cur_q) + NW'(1);
            div_req_o.dvs       = cfg_i.slots;
            st_d                = htw_pkg::ST_TDIV;
          end
        end
      end
      htw_pkg::ST_ADIV1: begin
        if (div_rsp_i.done) begin
          div_req_o.start = 1'b1;
          div_req_o.num   = NW'(ticks);
          div_req_o.dvs   = cfg_i.slots;
          st_d            = htw_pkg::ST_ADIV2;
        end
      end
      htw_pkg::ST_ADIV2: begin
        if (div_rsp_i.done) begin
          rounds_d = div_rsp_i.quot[31:0] + 32'(div_rsp_i.rem != '0);
          div_req_o.start     = 1'b1;
          div_req_o.short_len = 1'b1;
          div_req_o.num       = NW'(cur_q) + NW'(div_rsp_i.rem);
          div_req_o.dvs       = cfg_i.slots;
          st_d                = htw_pkg::ST_ADIV3;
        end
      end
      htw_pkg::ST_ADIV3: begin
        if (div_rsp_i.done) begin
          wr_en   = 1'b1;
          wr_addr = tsel;
          wr_data = {div_rsp_i.rem[SW-1:0], rounds_q};
          if (!armed_q[tsel]) begin
            cnt_d = cnt_q + CNTW'(1);
          end
          armed_d[tsel] = 1'b1;
          st_d          = htw_pkg::ST_ARES;
        end
      end
      htw_pkg::ST_ARES: begin
        res_o.valid        = 1'b1;
        res_o.kind         = htw_pkg::KIND_ADD;
        res_o.last         = 1'b1;
        res_o.active_count = 5'(cnt_q);
        if (res_ready_i) begin
          st_d = htw_pkg::ST_IDLE;
        end
      end
      htw_pkg::ST_TDIV: begin
        if (div_rsp_i.done) begin
          cur_d    = div_rsp_i.rem[SW-1:0];
          idx_d    = '0;
          hold_v_d = 1'b0;
          st_d     = htw_pkg::ST_RD;
        end
      end
      htw_pkg::ST_RD: begin
        if (armed_q[idx_q]) begin
          rd_en = 1'b1;
          st_d  = htw_pkg::ST_EV;
        end else if (idx_last) begin
          st_d = htw_pkg::ST_FIN;
        end else begin
          idx_d = idx_q + TW'(1);
        end
      end
      htw_pkg::ST_EV: begin
        if (expire && hold_v_q) begin
          res_o.valid         = 1'b1;
          res_o.kind          = htw_pkg::KIND_EXPIRE;
          res_o.expired_timer = 4'(hold_idx_q);
          res_o.active_count  = 5'(cnt_dec);
        end
        if (!expire || !hold_v_q || res_ready_i) begin
          if (expire) begin
            if (hold_v_q) begin
              cnt_d = cnt_dec;
            end
            hold_v_d       = 1'b1;
            hold_idx_d     = idx_q;
            armed_d[idx_q] = 1'b0;
          end else if (hit) begin
            wr_en   = 1'b1;
            wr_data = {ent_slot, ent_rounds - 32'd1};
          end
          if (idx_last) begin
            st_d = htw_pkg::ST_FIN;
          end else begin
            idx_d = idx_q + TW'(1);
            st_d  = htw_pkg::ST_RD;
          end
        end
      end
      htw_pkg::ST_FIN: begin
        res_o.valid = 1'b1;
        res_o.last  = 1'b1;
        if (hold_v_q) begin
          res_o.kind          = htw_pkg::KIND_EXPIRE;
          res_o.expired_timer = 4'(hold_idx_q);
          res_o.active_count  = 5'(cnt_dec);
        end else begin
          res_o.kind         = htw_pkg::KIND_EMPTY;
          res_o.active_count = 5'(cnt_q);
        end
        if (res_ready_i) begin
          if (hold_v_q) begin
            cnt_d = cnt_dec;
          end
          hold_v_d = 1'b0;
          st_d     = htw_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = htw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/hashed_timing_wheel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed timing wheel
// Timer table on a wheel of slots with round counts; adds arm timers, ticks
// advance the wheel and report expiries in ascending timer number.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  opcode, timer_number, time_span
//   out      output     out_valid_o/out_stall_i kind, expired_timer, last,
//                                               active_count
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// An add runs three divisions in turn on the shared one-bit-per-cycle
// divider: the span over the tick period, rounded up, then those ticks over
// the slots in use, then a short one that places the timer on its slot.
// A tick runs a short division to advance the wheel, then scans the
// table in timer order, reading armed entries through its single read port.
// Reset disarms all timers and puts the wheel at slot zero; no clearing pass.
// A stalled output holds the engine only when a further result is ready.
// ----------------------------------------------------------------------------
module hashed_timing_wheel #(
  parameter int unsigned NUM_TIMERS  = 16,
  parameter int unsigned WHEEL_SLOTS = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [htw_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [htw_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_opcode_i,
  input  logic [3:0]                   in_timer_number_i,
  input  logic [31:0]                  in_time_span_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   out_kind_o,
  output logic [3:0]                   out_expired_timer_o,
  output logic                         out_last_o,
  output logic [4:0]                   out_active_count_o
);

  localparam int unsigned SW = $clog2(WHEEL_SLOTS);
  localparam int unsigned DW = htw_pkg::DIV_DW;

  logic [15:0]       tick_period_q;
  logic [8:0]        slots_in_use_q;
  htw_pkg::cfg_t     cfg;
  htw_pkg::item_t    item;
  htw_pkg::res_t     res;
  htw_pkg::div_req_t div_req;
  htw_pkg::div_rsp_t div_rsp;
  logic              in_ready;
  logic              res_ready;

  logic          out_valid_q;
  htw_pkg::kind_e out_kind_q;
  logic [3:0]    out_timer_q;
  logic          out_last_q;
  logic [4:0]    out_active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q  <= 16'd1;
      slots_in_use_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        htw_pkg::CFG_TICK_PERIOD:  tick_period_q  <= cfg_data_i[15:0];
        htw_pkg::CFG_SLOTS_IN_USE: slots_in_use_q <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.period = (tick_period_q == 16'd0) ? 16'd1 : tick_period_q;
    if (slots_in_use_q == 9'd0) begin
      cfg.slots = DW'(1);
    end else if (DW'(slots_in_use_q) > DW'(WHEEL_SLOTS)) begin
      cfg.slots = DW'(WHEEL_SLOTS);
    end else begin
      cfg.slots = DW'(slots_in_use_q);
    end
  end

  assign item.opcode       = htw_pkg::op_e'(in_opcode_i);
  assign item.timer_number = in_timer_number_i;
  assign item.time_span    = in_time_span_i;
  assign in_stall_o        = !in_ready;

  htw_div #(
    .SHORT_ITERS(SW + 1)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  htw_core #(
    .NUM_TIMERS (NUM_TIMERS),
    .WHEEL_SLOTS(WHEEL_SLOTS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready),
    .in_item_i  (item),
    .res_o      (res),
    .res_ready_i(res_ready),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_kind_q   <= res.kind;
      out_timer_q  <= res.expired_timer;
      out_last_q   <= res.last;
      out_active_q <= res.active_count;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_kind_o          = out_kind_q;
  assign out_expired_timer_o = out_timer_q;
  assign out_last_o          = out_last_q;
  assign out_active_count_o  = out_active_q;

endmodule

### rtl/htw_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timing wheel port checker
// Concurrent checks on the result channel of the timing wheel.
// ----------------------------------------------------------------------------
module htw_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] out_kind_o,
  input logic [3:0] out_expired_timer_o,
  input logic       out_last_o
);

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kind_o == htw_pkg::KIND_ADD) ||
                    (out_kind_o == htw_pkg::KIND_EXPIRE) ||
                    (out_kind_o == htw_pkg::KIND_EMPTY))
    else $error("result kind out of range");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o != htw_pkg::KIND_EXPIRE) |-> out_last_o)
    else $error("add or empty tick result without last");

  a_timer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o != htw_pkg::KIND_EXPIRE) |-> out_expired_timer_o == 4'd0)
    else $error("timer number set on a result without expiry");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o) &&
                                   $stable(out_expired_timer_o) && $stable(out_last_o))
    else $error("stalled result changed");

endmodule

bind hashed_timing_wheel htw_chk u_htw_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .out_kind_o         (out_kind_o),
  .out_expired_timer_o(out_expired_timer_o),
  .out_last_o         (out_last_o)
);
